FILE: sv/k_permutation_generator_top_macros.svh
// Assertion macros for the k-permutation generator.
// The enclosing module provides clk_i and rst_ni.
`ifndef K_PERMUTATION_GENERATOR_TOP_MACROS_SVH
`define K_PERMUTATION_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define KPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kpg: property violated");

`define KPG_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kpg: forbidden condition seen");

`else

`define KPG_ASSERT(lbl, prop)

`define KPG_NEVER(lbl, cond)

`endif

`endif

FILE: sv/kpg_pkg.sv
`timescale 1ns / 1ps

package kpg_pkg;

  localparam int CNT_W    = 5;   // width of the n and k registers
  localparam int SLOT_W   = 4;   // width of one slot index and one symbol
  localparam int POOL_W   = 16;  // width of the taken mask
  localparam int NIB_CNT  = 16;  // symbol positions in the packed word
  localparam int SYM_W    = 64;
  localparam int SEQ_W    = 45;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 2;

  // configuration register indexes
  localparam logic CFG_CANDIDATE = 1'b0;
  localparam logic CFG_PICKED    = 1'b1;

  typedef struct packed {
    logic              valid_res;
    logic              config_error;
    logic [SEQ_W-1:0]  sequence_number;
    logic [SYM_W-1:0]  symbols;
    logic              last_one;
  } res_t;

endpackage

FILE: sv/k_permutation_generator_top.sv
`timescale 1ns / 1ps
// Lexicographic k-permutation generator. Each input transaction asks for the
// next ordered selection of k symbols out of n (restart = 1 starts over at
// the first one) and returns exactly one result transaction. The slot
// indices live in a one-port-read, one-port-write slot memory. A request
// with bad registers, or after the final permutation, skips the slot memory
// and goes straight to the result. A restart (or the first request after
// reset or a register write) makes one slot memory write per position.
// On an advance the rightmost movable slot is found
// by reading the slot memory one slot per cycle from position k-1 down, then
// the positions from that slot to k-1 are rebuilt and written back, one per
// cycle. A new request is taken once the previous one has moved into the
// output register. Register writes reset the enumeration.
`include "k_permutation_generator_top_macros.svh"

module k_permutation_generator_top #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_addr_i,
  input  logic [kpg_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: restart[0], zero pad[7:1]
  input  logic [kpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: sequence_number[44:0], symbols[108:45], zero pad[111:109]
  output logic [kpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: valid_res[0], config_error[1]
  output logic [kpg_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                            m_axis_tlast
);
  import kpg_pkg::*;

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_SYMBOLS);

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_SCAN_ISSUE = 6'b000010,
    ST_SCAN       = 6'b000100,
    ST_DECODE     = 6'b001000,
    ST_CHECK      = 6'b010000,
    ST_FINISH     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  n_q, n_d, k_q, k_d;
  logic [SEQ_W-1:0]  cnt_q, cnt_d;
  logic              exh_q, exh_d;
  logic [AW-1:0]     chk_q, chk_d;
  logic [AW-1:0]     pivot_q, pivot_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [SLOT_W-1:0] pval_q, pval_d;
  logic [POOL_W-1:0] mask_q, mask_d;
  logic [SYM_W-1:0]  word_q, word_d;
  res_t              bld_q, bld_d;

  logic              acc;
  logic              cfg_bad;
  logic [CNT_W-1:0]  k_m1;
  logic              out_free;
  logic              out_load;

  logic              mem_we;
  logic [AW-1:0]     mem_raddr;
  logic [SLOT_W-1:0] mem_rdata;
  logic [SLOT_W-1:0] want;
  logic [SLOT_W-1:0] pick;
  logic              can_move;
  logic [POOL_W-1:0] prefix_mask;
  logic              fin;
  logic [CNT_W-1:0]  top_sym;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign k_m1          = k_q - CNT_W'(1);
  assign cfg_bad       = (n_q == '0) || (k_q == '0) || (n_q > MaxCnt) ||
                         (k_q > MaxCnt) || (k_q > n_q);

  // slot under test can still grow
  assign can_move = ({1'b0, mem_rdata} + CNT_W'(1)) < (n_q - CNT_W'(chk_q));

  // symbols taken by positions left of the scan point, from the last word
  always_comb begin
    prefix_mask = '0;
    for (int p = 0; p < NIB_CNT; p++) begin
      if (p < int'(chk_q)) begin
        prefix_mask = prefix_mask | (POOL_W'(1) << word_q[p*SLOT_W +: SLOT_W]);
      end
    end
  end

  // final permutation: position p holds symbol n-1-p for every p below k
  always_comb begin
    fin = 1'b1;
    top_sym = '0;
    for (int p = 0; p < NIB_CNT; p++) begin
      top_sym = n_q - CNT_W'(1) - CNT_W'(p);
      if ((CNT_W'(p) < k_q) && ({1'b0, word_q[p*SLOT_W +: SLOT_W]} != top_sym)) begin
        fin = 1'b0;
      end
    end
  end

  assign want = (pos_q == pivot_q) ? pval_q : '0;

  kpg_pick u_pick (
    .mask_i (mask_q),
    .want_i (want),
    .n_i    (n_q),
    .pick_o (pick)
  );

  // scan reads finish before the rebuild writes start: no overlap on an entry
  assign mem_we    = (state_q == ST_DECODE);
  assign mem_raddr = (state_q == ST_SCAN) ? (chk_q - AW'(1)) : chk_q;

  kpg_slot_mem #(
    .DEPTH (MAX_SYMBOLS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q),
    .wdata_i (want),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_load = (state_q == ST_FINISH) && out_free;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    exh_d   = exh_q;
    chk_d   = chk_q;
    pivot_d = pivot_q;
    pos_d   = pos_q;
    pval_d  = pval_q;
    mask_d  = mask_q;
    word_d  = word_q;
    bld_d   = bld_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          unique case (cfg_addr_i)
            CFG_CANDIDATE: n_d = cfg_wdata_i;
            CFG_PICKED:    k_d = cfg_wdata_i;
            default:       n_d = n_q;
          endcase
          cnt_d = '0;
          exh_d = 1'b0;
        end
        if (acc) begin
          priority if (cfg_bad) begin
            bld_d = '0;
            bld_d.config_error = 1'b1;
            state_d = ST_FINISH;
          end else if (s_axis_tdata[0] || ((cnt_q == '0) && !exh_q)) begin
            // start the walk over: the first permutation is number one
            cnt_d   = '0;
            pivot_d = '0;
            pval_d  = '0;
            pos_d   = '0;
            mask_d  = '0;
            word_d  = '0;
            state_d = ST_DECODE;
          end else if (exh_q) begin
            bld_d   = '0;
            state_d = ST_FINISH;
          end else begin
            chk_d   = k_m1[AW-1:0];
            state_d = ST_SCAN_ISSUE;
          end
        end
      end
      ST_SCAN_ISSUE: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (can_move) begin
          pivot_d = chk_q;
          pos_d   = chk_q;
          pval_d  = mem_rdata + SLOT_W'(1);
          mask_d  = prefix_mask;
          state_d = ST_DECODE;
        end else if (chk_q == '0) begin
          exh_d   = 1'b1;
          bld_d   = '0;
          state_d = ST_FINISH;
        end else begin
          chk_d = chk_q - AW'(1);
        end
      end
      ST_DECODE: begin
        mask_d = mask_q | (POOL_W'(1) << pick);
        for (int p = 0; p < NIB_CNT; p++) begin
          if (p == int'(pos_q)) begin
            word_d[p*SLOT_W +: SLOT_W] = pick;
          end
        end
        if (CNT_W'(pos_q) == k_m1) begin
          state_d = ST_CHECK;
        end else begin
          pos_d = pos_q + AW'(1);
        end
      end
      ST_CHECK: begin
        bld_d.valid_res       = 1'b1;
        bld_d.config_error    = 1'b0;
        bld_d.sequence_number = cnt_q + SEQ_W'(1);
        bld_d.symbols         = word_q;
        bld_d.last_one        = fin;
        cnt_d   = cnt_q + SEQ_W'(1);
        exh_d   = fin;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= CNT_W'(4);
      k_q     <= CNT_W'(3);
      cnt_q   <= '0;
      exh_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      exh_q   <= exh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q   <= chk_d;
    pivot_q <= pivot_d;
    pos_q   <= pos_d;
    pval_q  <= pval_d;
    mask_q  <= mask_d;
    word_q  <= word_d;
    bld_q   <= bld_d;
  end

  kpg_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .res_i         (bld_q),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `KPG_NEVER(a_err_with_valid, m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[0])
  `KPG_NEVER(a_last_without_valid, m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0])
  `KPG_ASSERT(a_cnt_source, (cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_CHECK || $past(cfg_we_i) || $past(acc)))
  `KPG_ASSERT(a_exh_rise, $rose(exh_q) |-> (state_q == ST_FINISH))

endmodule

FILE: sv/kpg_slot_mem.sv
`timescale 1ns / 1ps

module kpg_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [kpg_pkg::SLOT_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [kpg_pkg::SLOT_W-1:0] rdata_o
);
  import kpg_pkg::*;

  logic [SLOT_W-1:0] mem_q [DEPTH];
  logic [SLOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/kpg_pick.sv
`timescale 1ns / 1ps

// Select the symbol that is the want-th free one among symbols below n.
module kpg_pick (
  input  logic [kpg_pkg::POOL_W-1:0] mask_i,
  input  logic [kpg_pkg::SLOT_W-1:0] want_i,
  input  logic [kpg_pkg::CNT_W-1:0]  n_i,
  output logic [kpg_pkg::SLOT_W-1:0] pick_o
);
  import kpg_pkg::*;

  logic [POOL_W-1:0] free;
  logic [POOL_W-1:0] below;

  always_comb begin
    for (int s = 0; s < POOL_W; s++) begin
      free[s] = !mask_i[s] && (CNT_W'(s) < n_i);
    end
  end

  always_comb begin
    pick_o = '0;
    below  = '0;
    for (int s = 0; s < POOL_W; s++) begin
      below = free & ((POOL_W'(1) << s) - POOL_W'(1));
      if (free[s] && (CNT_W'($countones(below)) == {1'b0, want_i})) begin
        pick_o = SLOT_W'(s);
      end
    end
  end

endmodule

FILE: sv/kpg_out_reg.sv
`timescale 1ns / 1ps

module kpg_out_reg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  kpg_pkg::res_t                   res_i,
  output logic                            free_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: sequence_number[44:0], symbols[108:45], zero pad[111:109]
  output logic [kpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: valid_res[0], config_error[1]
  output logic [kpg_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                            m_axis_tlast
);
  import kpg_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - SYM_W - SEQ_W)'(0), res_q.symbols,
                          res_q.sequence_number};
  assign m_axis_tuser  = {res_q.config_error, res_q.valid_res};
  assign m_axis_tlast  = res_q.last_one;

endmodule

FILE: tb/k_permutation_generator_top_tb.sv
`timescale 1ns / 1ps

module k_permutation_generator_top_tb;
  import kpg_pkg::*;

  localparam int SETTLE_CYCLES = 2 * 16 + 8;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int MAX_PRINTS    = 40;

  typedef enum logic [1:0] {STIM_REQ, STIM_REG, STIM_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e       kind;
    logic             restart;
    logic             addr;
    logic [CNT_W-1:0] value;
  } stim_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_addr_i = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  k_permutation_generator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Permutation walk state mirrored from the block
  logic [CNT_W-1:0]  pool_size = 5'd4;
  logic [CNT_W-1:0]  pick_size = 5'd3;
  logic [SLOT_W-1:0] slot_idx [NIB_CNT];
  logic [SEQ_W-1:0]  perm_count;
  logic              walk_done;

  stim_t stim_q [$];
  res_t  expected_perms [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int requests_taken = 0;
  int reg_writes     = 0;
  int final_perms    = 0;
  int past_end_cnt   = 0;
  int bad_reg_cnt    = 0;
  int total_reqs     = 0;
  int quiet_cycles   = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int idle_cycles    = 0;
  bit no_idle        = 1'b0;

  logic                  drv_valid;
  logic [IN_TDATA_W-1:0] drv_data;
  logic                  drv_we;
  logic                  drv_addr;
  logic [CNT_W-1:0]      drv_wdata;
  res_t                  want_res;

  function automatic void clear_walk();
    for (int i = 0; i < NIB_CNT; i++) slot_idx[i] = '0;
    perm_count = '0;
    walk_done  = 1'b0;
  endfunction

  function automatic void apply_reg_write(input logic addr, input logic [CNT_W-1:0] val);
    if (addr == CFG_CANDIDATE) pool_size = val;
    else pick_size = val;
    clear_walk();
  endfunction

  // Compute the next permutation for one request and update the walk state.
  function automatic res_t next_permutation(input logic restart);
    res_t              r;
    int                n, k, want, pick;
    logic [POOL_W-1:0] mask;
    logic [SYM_W-1:0]  word;
    logic              moved, found, fin;
    r = '0;
    n = pool_size;
    k = pick_size;
    if (n == 0 || k == 0 || n > 16 || k > 16 || k > n) begin
      r.config_error = 1'b1;
      bad_reg_cnt++;
      return r;
    end
    if (restart || (perm_count == 0 && !walk_done)) begin
      clear_walk();
    end else if (walk_done) begin
      past_end_cnt++;
      return r;
    end else begin
      moved = 1'b0;
      for (int j = k - 1; j >= 0 && !moved; j--) begin
        if (int'(slot_idx[j]) + 1 < n - j) begin
          slot_idx[j] = slot_idx[j] + 1'b1;
          for (int t = j + 1; t < k; t++) slot_idx[t] = '0;
          moved = 1'b1;
        end
      end
      if (!moved) begin
        walk_done = 1'b1;
        past_end_cnt++;
        return r;
      end
    end
    // map each slot index onto the symbols not yet taken
    mask = '0;
    word = '0;
    for (int i = 0; i < k; i++) begin
      want  = slot_idx[i];
      pick  = 0;
      found = 1'b0;
      for (int s = 0; s < n; s++) begin
        if (!found && !mask[s]) begin
          if (want == 0) begin
            pick  = s;
            found = 1'b1;
          end else begin
            want--;
          end
        end
      end
      mask[pick]      = 1'b1;
      word[4*i +: 4]  = pick[3:0];
    end
    perm_count        = perm_count + 1'b1;
    r.valid_res       = 1'b1;
    r.sequence_number = perm_count;
    r.symbols         = word;
    fin = 1'b1;
    for (int i = 0; i < k; i++)
      if (int'(slot_idx[i]) + 1 != n - i) fin = 1'b0;
    if (fin) begin
      r.last_one = 1'b1;
      walk_done  = 1'b1;
      final_perms++;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: %s mismatch on result %0d: got %0h, expected %0h",
               $time, field, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic add_req(input logic restart);
    stim_t e;
    e.kind    = STIM_REQ;
    e.restart = restart;
    e.addr    = 1'b0;
    e.value   = '0;
    stim_q.insert(stim_q.size(), e);
    total_reqs++;
  endtask

  task automatic add_reg(input logic addr, input logic [CNT_W-1:0] val);
    stim_t e;
    e.kind    = STIM_REG;
    e.restart = 1'b0;
    e.addr    = addr;
    e.value   = val;
    stim_q.insert(stim_q.size(), e);
  endtask

  task automatic add_drain();
    stim_t e;
    e.kind    = STIM_DRAIN;
    e.restart = 1'b0;
    e.addr    = 1'b0;
    e.value   = '0;
    stim_q.insert(stim_q.size(), e);
  endtask

  task automatic add_setting(input int n, input int k);
    add_reg(CFG_CANDIDATE, n[CNT_W-1:0]);
    add_reg(CFG_PICKED, k[CNT_W-1:0]);
  endtask

  // Driver: requests and register writes, one nonblocking update per signal
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      cfg_we_i      <= 1'b0;
      cfg_addr_i    <= 1'b0;
      cfg_wdata_i   <= '0;
      clear_walk();
    end else begin
      drv_valid = s_axis_tvalid;
      drv_data  = s_axis_tdata;
      drv_we    = 1'b0;
      drv_addr  = cfg_addr_i;
      drv_wdata = cfg_wdata_i;
      quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) quiet_cycles = 0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_perms.insert(expected_perms.size(), next_permutation(s_axis_tdata[0]));
        requests_taken++;
        quiet_cycles = 0;
        drv_valid    = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          case (stim_q[0].kind)
            STIM_REQ: begin
              drv_valid = 1'b1;
              drv_data  = '0;
              drv_data[0] = stim_q[0].restart;
              stim_q.pop_front();
              gap_left = pick_gap();
            end
            STIM_REG: begin
              // write only with nothing in flight and the block settled
              if (expected_perms.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                drv_we    = 1'b1;
                drv_addr  = stim_q[0].addr;
                drv_wdata = stim_q[0].value;
                apply_reg_write(stim_q[0].addr, stim_q[0].value);
                reg_writes++;
                no_idle <= ($urandom_range(0, 4) == 0);
                stim_q.pop_front();
              end
            end
            default: begin
              if (expected_perms.size() == 0) stim_q.pop_front();
            end
          endcase
        end
      end
      s_axis_tvalid <= drv_valid;
      s_axis_tdata  <= drv_data;
      cfg_we_i      <= drv_we;
      cfg_addr_i    <= drv_addr;
      cfg_wdata_i   <= drv_wdata;
    end
  end

  // Monitor: back-pressure and result checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_perms.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata[63:0], '0);
        end else begin
          want_res = expected_perms.pop_front();
          if (m_axis_tuser[0] !== want_res.valid_res)
            report_mismatch("valid_res", m_axis_tuser[0], want_res.valid_res);
          if (m_axis_tuser[1] !== want_res.config_error)
            report_mismatch("config_error", m_axis_tuser[1], want_res.config_error);
          if (m_axis_tdata[SEQ_W-1:0] !== want_res.sequence_number)
            report_mismatch("sequence_number", m_axis_tdata[SEQ_W-1:0],
                            want_res.sequence_number);
          if (m_axis_tdata[SEQ_W +: SYM_W] !== want_res.symbols)
            report_mismatch("symbols", m_axis_tdata[SEQ_W +: SYM_W], want_res.symbols);
          if (m_axis_tlast !== want_res.last_one)
            report_mismatch("last_one", m_axis_tlast, want_res.last_one);
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("** k_permutation_generator_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int n, k, r, cnt, base;
    // reset values, first advance acts as a restart
    for (int i = 0; i < 4; i++) add_req(1'b0);
    add_req(1'b1);
    add_req(1'b0);
    // single permutation, then past the end, then restart
    add_setting(1, 1);
    add_req(1'b0);
    add_req(1'b0);
    add_req(1'b0);
    add_req(1'b1);
    add_setting(2, 2);
    add_req(1'b0);
    add_req(1'b0);
    add_req(1'b0);
    add_drain();
    // bad registers: k above n, zero sizes, sizes above the pool
    add_setting(3, 4);
    add_req(1'b0);
    add_req(1'b1);
    add_setting(0, 1);
    add_req(1'b0);
    add_setting(16, 0);
    add_req(1'b0);
    add_setting(16, 17);
    add_req(1'b0);
    add_setting(31, 31);
    add_req(1'b1);
    // widest selection fills every nibble
    add_setting(16, 16);
    add_req(1'b1);
    add_req(1'b0);
    add_req(1'b0);
    add_setting(16, 1);
    add_req(1'b0);
    add_req(1'b0);
    base = total_reqs;

    while (total_reqs - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        n = $urandom_range(0, 31);
        k = $urandom_range(0, 31);
      end else if (r <= 3) begin
        n = $urandom_range(9, 16);
        k = $urandom_range(1, n);
      end else begin
        n = $urandom_range(1, 6);
        k = $urandom_range(1, n);
      end
      r = $urandom_range(0, 9);
      if (r == 0) add_reg(CFG_CANDIDATE, n[CNT_W-1:0]);
      else if (r == 1) add_reg(CFG_PICKED, k[CNT_W-1:0]);
      else add_setting(n, k);
      cnt = $urandom_range(10, 60);
      for (int i = 0; i < cnt; i++) add_req($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 7) == 0) add_drain();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || expected_perms.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_perms.size() != 0)
      report_mismatch("missing transactions", expected_perms.size(), 0);
    $display("Checked %0d results from %0d requests across %0d register writes.",
             results_seen, requests_taken, reg_writes);
    $display("%0d walks ran to the final permutation, %0d requests came past the end, %0d hit bad registers.",
             final_perms, past_end_cnt, bad_reg_cnt);
    if (mismatch_count == 0) begin
      $display("** k_permutation_generator_top: PASSED **");
    end else begin
      $display("** k_permutation_generator_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/kpg_pkg.sv
sv/kpg_slot_mem.sv
sv/kpg_pick.sv
sv/kpg_out_reg.sv
sv/k_permutation_generator_top.sv
tb/k_permutation_generator_top_tb.sv
